FILE: design/mbe_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel unit.
// Depends on nothing; every other file in the design imports it.
package mbe_pkg;

   localparam int MAX_ITER_LIMIT_DEF = 4096;
   localparam int MAX_DIM_DEF        = 4096;

   localparam int COORD_W = 12;
   localparam int COUNT_W = 13;
   localparam int COLOR_W = 24;
   localparam int CPX_W   = 44;   // c in Q16.28, never wraps
   localparam int ZW      = 45;   // z components before the escape test
   localparam int NUM_W   = 21;   // blend numerator, at most 255 * 8191

   localparam logic [2:0] REG_X_MIN       = 3'd0;
   localparam logic [2:0] REG_X_STEP      = 3'd1;
   localparam logic [2:0] REG_Y_MIN       = 3'd2;
   localparam logic [2:0] REG_Y_STEP      = 3'd3;
   localparam logic [2:0] REG_MAX_ITER    = 3'd4;
   localparam logic [2:0] REG_COLOR_START = 3'd5;
   localparam logic [2:0] REG_COLOR_END   = 3'd6;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] row;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iter_count;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [CPX_W-1:0] cr;
      logic signed [CPX_W-1:0] ci;
   } point_type;

endpackage

FILE: design/mandelbrot_escape_time_pixel_unit.sv
// Top level of the Mandelbrot escape-time pixel unit: configuration
// registers and the front, queue and back sections. Depends on mbe_pkg.
//
// Usage. A request carries one pixel's column and row on req_payload and
// is taken at a rising edge where req_valid is high and req_stall is low.
// Each request produces exactly one response on rsp_payload: the iteration
// count and the blended red, green and blue values, offered with rsp_valid
// and held unchanged while rsp_stall is high.
// Path: the front-end register and the queue, the back end's idle state,
// then for each iteration of z = z*z + c a multiply and an add/compare
// state. The loop ends in the check state on the count or magnitude test,
// or in the add/compare state on the radius test; the blend numerators,
// the bit-serial divider and the output register follow. The iteration
// loop sets the sustained rate; the front end maps later points meanwhile,
// with up to two of them waiting in the queue. When the receiver stalls,
// the result waits in the output register, the back end holds, and the
// queue and then req_stall back up. Reset empties every stage and loads
// the default view (-2.0 left, -1.0 top, 256 iterations, black to white).
// The user must write configuration through the csr_ port only while no
// request is in flight; the block itself does not enforce this.
module mandelbrot_escape_time_pixel_unit #(
   parameter int MAX_ITER_LIMIT = mbe_pkg::MAX_ITER_LIMIT_DEF,
   parameter int MAX_DIM        = mbe_pkg::MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mbe_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output mbe_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [4:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);
   import mbe_pkg::*;

   logic signed [31:0]  x_min_ff, x_step_ff, y_min_ff, y_step_ff;
   logic [COUNT_W-1:0]  max_iter_ff;
   logic [COLOR_W-1:0]  color_start_ff, color_end_ff;
   logic                csr_write;
   logic [2:0]          csr_index;

   logic                pt_valid, pt_ready, q_valid, q_pop;
   point_type           pt_data, q_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   // Register writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff       <= 32'hE000_0000;
         x_step_ff      <= 32'd786432;
         y_min_ff       <= 32'hF000_0000;
         y_step_ff      <= 32'd786432;
         max_iter_ff    <= 13'd256;
         color_start_ff <= 24'h000000;
         color_end_ff   <= 24'hFFFFFF;
      end else if (csr_write) begin
         case (csr_index)
            REG_X_MIN:       x_min_ff       <= csr_pwdata;
            REG_X_STEP:      x_step_ff      <= csr_pwdata;
            REG_Y_MIN:       y_min_ff       <= csr_pwdata;
            REG_Y_STEP:      y_step_ff      <= csr_pwdata;
            REG_MAX_ITER:    max_iter_ff    <= csr_pwdata[COUNT_W-1:0];
            REG_COLOR_START: color_start_ff <= csr_pwdata[COLOR_W-1:0];
            REG_COLOR_END:   color_end_ff   <= csr_pwdata[COLOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_X_MIN:       csr_prdata = x_min_ff;
         REG_X_STEP:      csr_prdata = x_step_ff;
         REG_Y_MIN:       csr_prdata = y_min_ff;
         REG_Y_STEP:      csr_prdata = y_step_ff;
         REG_MAX_ITER:    csr_prdata = 32'(max_iter_ff);
         REG_COLOR_START: csr_prdata = 32'(color_start_ff);
         REG_COLOR_END:   csr_prdata = 32'(color_end_ff);
         default:         csr_prdata = '0;
      endcase
   end

   mbe_front #(.MAX_DIM(MAX_DIM)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .x_min       (x_min_ff),
      .x_step      (x_step_ff),
      .y_min       (y_min_ff),
      .y_step      (y_step_ff),
      .pt_valid    (pt_valid),
      .pt_ready    (pt_ready),
      .pt_data     (pt_data)
   );

   mbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (pt_valid),
      .push_ready (pt_ready),
      .push_data  (pt_data),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_data   (q_data)
   );

   mbe_back #(.MAX_ITER_LIMIT(MAX_ITER_LIMIT)) u_back (
      .clock          (clock),
      .reset          (reset),
      .pt_valid       (q_valid),
      .pt_pop         (q_pop),
      .pt_data        (q_data),
      .max_iterations (max_iter_ff),
      .color_start    (color_start_ff),
      .color_end      (color_end_ff),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_payload    (rsp_payload)
   );

endmodule

FILE: design/mbe_front.sv
// Front end: maps a pixel request to its complex point c and holds it.
// Depends on mbe_pkg.
module mbe_front #(
   parameter int MAX_DIM = mbe_pkg::MAX_DIM_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  mbe_pkg::req_payload_type req_payload,
   input  logic signed [31:0]       x_min,
   input  logic signed [31:0]       x_step,
   input  logic signed [31:0]       y_min,
   input  logic signed [31:0]       y_step,
   output logic                     pt_valid,
   input  logic                     pt_ready,
   output mbe_pkg::point_type       pt_data
);
   import mbe_pkg::*;

   logic                 valid_ff, valid_in;
   point_type            point_ff, point_in;
   logic [COORD_W-1:0]   col_sat, row_sat;
   logic signed [44:0]   prod_x, prod_y;
   logic                 load;

   // Indices beyond the image clamp to its last column or row.
   always_comb begin
      col_sat = ({5'b0, req_payload.column} >= 17'(MAX_DIM)) ?
                COORD_W'(MAX_DIM - 1) : req_payload.column;
      row_sat = ({5'b0, req_payload.row} >= 17'(MAX_DIM)) ?
                COORD_W'(MAX_DIM - 1) : req_payload.row;
      prod_x  = $signed({1'b0, col_sat}) * x_step;
      prod_y  = $signed({1'b0, row_sat}) * y_step;
      point_in.cr = CPX_W'(prod_x + 45'(x_min));
      point_in.ci = CPX_W'(prod_y + 45'(y_min));
   end

   assign req_stall = valid_ff && !pt_ready;
   assign load      = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      if (valid_ff && pt_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         point_ff <= point_in;
      end
   end

   assign pt_valid = valid_ff;
   assign pt_data  = point_ff;

endmodule

FILE: design/mbe_queue.sv
// Two-entry queue of complex points between the front and back ends.
// Depends on mbe_pkg.
module mbe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  mbe_pkg::point_type push_data,
   output logic               pop_valid,
   input  logic               pop,
   output mbe_pkg::point_type pop_data
);
   import mbe_pkg::*;

   point_type   mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/mbe_back.sv
// Back end: iterates z = z*z + c, blends the color with a bit-serial
// divider and holds the result in the output register. Depends on mbe_pkg.
module mbe_back #(
   parameter int MAX_ITER_LIMIT = mbe_pkg::MAX_ITER_LIMIT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pt_valid,
   output logic                        pt_pop,
   input  mbe_pkg::point_type          pt_data,
   input  logic [mbe_pkg::COUNT_W-1:0] max_iterations,
   input  logic [mbe_pkg::COLOR_W-1:0] color_start,
   input  logic [mbe_pkg::COLOR_W-1:0] color_end,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output mbe_pkg::rsp_payload_type    rsp_payload
);
   import mbe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_CHECK, ST_SUM, ST_NUM, ST_DIV, ST_OUT
   } state_type;

   localparam logic [COUNT_W-1:0] LIMIT =
      (MAX_ITER_LIMIT > 8191) ? 13'h1FFF : COUNT_W'(MAX_ITER_LIMIT);
   localparam logic signed [ZW-1:0]  TWO_Q28  = 45'sd1 <<< 29;
   localparam logic signed [ZW-1:0]  MTWO_Q28 = -(45'sd1 <<< 29);
   localparam logic signed [61:0]    FOUR_Q56 = 62'sd1 <<< 58;

   state_type               state_ff;
   logic signed [ZW-1:0]    x_ff, y_ff;
   logic signed [CPX_W-1:0] cr_ff, ci_ff;
   logic [COUNT_W-1:0]      cnt_ff, mx_ff, mx_in;
   logic signed [61:0]      xx_ff, yy_ff, xy_ff;
   logic [13:0]             rem_ff [3];
   logic [NUM_W-1:0]        quo_ff [3];
   logic [4:0]              bit_ff;
   logic                    rsp_valid_ff;
   rsp_payload_type         rsp_ff;

   logic signed [30:0]      xs, ys;
   logic                    escaped_abs;
   logic signed [ZW-1:0]    nx, ny;
   logic [7:0]              c1 [3];
   logic [7:0]              c2 [3];
   logic [13:0]             trial [3];
   logic [COUNT_W-1:0]      diff;

   always_comb begin
      mx_in = (max_iterations == '0) ? COUNT_W'(1) : max_iterations;
      if (mx_in > LIMIT) begin
         mx_in = LIMIT;
      end
      xs = x_ff[30:0];
      ys = y_ff[30:0];
      escaped_abs = (x_ff >= TWO_Q28) || (x_ff <= MTWO_Q28) ||
                    (y_ff >= TWO_Q28) || (y_ff <= MTWO_Q28);
      nx = ZW'(xx_ff - yy_ff >>> 28) + ZW'(cr_ff);
      ny = ZW'(xy_ff >>> 27) + ZW'(ci_ff);
      diff = mx_ff - cnt_ff;
      for (int i = 0; i < 3; i++) begin
         c1[i]    = color_start[8*(2-i) +: 8];
         c2[i]    = color_end[8*(2-i) +: 8];
         trial[i] = {rem_ff[i][12:0], quo_ff[i][NUM_W-1]};
      end
   end

   assign pt_pop = (state_ff == ST_IDLE) && pt_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A new result replaces the one leaving; otherwise an accepted one clears.
         if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pt_valid) begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               if (cnt_ff >= mx_ff || escaped_abs) begin
                  state_ff <= ST_NUM;
               end else begin
                  state_ff <= ST_SUM;
               end
            end
            ST_SUM: begin
               if (xx_ff + yy_ff >= FOUR_Q56) begin
                  state_ff <= ST_NUM;
               end else begin
                  state_ff <= ST_CHECK;
               end
            end
            ST_NUM: begin
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (bit_ff == 5'(NUM_W - 1)) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            x_ff   <= '0;
            y_ff   <= '0;
            cnt_ff <= '0;
            cr_ff  <= pt_data.cr;
            ci_ff  <= pt_data.ci;
            mx_ff  <= mx_in;
         end
         ST_CHECK: begin
            xx_ff <= xs * xs;
            yy_ff <= ys * ys;
            xy_ff <= xs * ys;
         end
         ST_SUM: begin
            if (xx_ff + yy_ff < FOUR_Q56) begin
               x_ff   <= nx;
               y_ff   <= ny;
               cnt_ff <= cnt_ff + 1'b1;
            end
         end
         ST_NUM: begin
            bit_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               rem_ff[i] <= '0;
               quo_ff[i] <= NUM_W'(c1[i]) * NUM_W'(diff) + NUM_W'(c2[i]) * NUM_W'(cnt_ff);
            end
         end
         ST_DIV: begin
            bit_ff <= bit_ff + 1'b1;
            for (int i = 0; i < 3; i++) begin
               if (trial[i] >= {1'b0, mx_ff}) begin
                  rem_ff[i] <= trial[i] - {1'b0, mx_ff};
                  quo_ff[i] <= {quo_ff[i][NUM_W-2:0], 1'b1};
               end else begin
                  rem_ff[i] <= trial[i];
                  quo_ff[i] <= {quo_ff[i][NUM_W-2:0], 1'b0};
               end
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_ff.iter_count <= cnt_ff;
               rsp_ff.red        <= quo_ff[0][7:0];
               rsp_ff.green      <= quo_ff[1][7:0];
               rsp_ff.blue       <= quo_ff[2][7:0];
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
